[rtl/prioritized_replay_sampler_defines.svh]
// assertion macros for the prioritized replay sampler checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PRIORITIZED_REPLAY_SAMPLER_DEFINES_SVH
`define PRIORITIZED_REPLAY_SAMPLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prs check failed");

// next-cycle implication, disabled during reset
`define PRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prs check failed");

`endif

[rtl/prs_pkg.sv]
// shared widths, codes, control structs and the exp2 step table
// no dependencies
package prs_pkg;

  localparam int CMD_W    = 2;
  localparam int PRI_W    = 24;
  localparam int SLOT_W   = 10;
  localparam int NEED_W   = 11;
  localparam int DRAW_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 11;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  // weight of one slot, Q.16, at most m << 9 with m below 2^25
  localparam int WW       = 34;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINP  = 1'd1;

  localparam logic [CFG_W-1:0] ALPHA_RST = 16'd19661;
  localparam logic [CFG_W-1:0] MINP_RST  = 16'd1;

  localparam logic [PRI_W-1:0] Q16_ONE = 24'h010000;
  localparam logic [24:0]      M_ONE   = 25'h1000000;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic w_start;
    logic sum_acc;
    logic calc_tgt;
    logic src_acc;
    logic load_out;
  } prs_cmd_t;

  typedef struct packed {
    logic sample_go;
    logic w_done;
    logic idx_last;
    logic hit;
  } prs_sts_t;

  // 2^(2^-k) in Q1.24, k = idx + 1
  function automatic logic [24:0] exp2_step(input logic [3:0] idx);
    logic [24:0] r;
    case (idx)
      4'd0:  r = 25'd23726566;
      4'd1:  r = 25'd19951585;
      4'd2:  r = 25'd18295684;
      4'd3:  r = 25'd17520007;
      4'd4:  r = 25'd17144589;
      4'd5:  r = 25'd16959908;
      4'd6:  r = 25'd16868315;
      4'd7:  r = 25'd16822704;
      4'd8:  r = 25'd16799944;
      4'd9:  r = 25'd16788576;
      4'd10: r = 25'd16782895;
      4'd11: r = 25'd16780055;
      4'd12: r = 25'd16778636;
      4'd13: r = 25'd16777926;
      4'd14: r = 25'd16777571;
      default: r = 25'd16777393;
    endcase
    return r;
  endfunction

endpackage

[rtl/prs_in_if.sv]
// input command channel of the replay sampler
// depends on prs_pkg
interface prs_in_if;
  import prs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [PRI_W-1:0]  new_priority;
  logic [SLOT_W-1:0] slot;
  logic [NEED_W-1:0] required_count;
  logic [DRAW_W-1:0] random_draw;

  modport source(output valid, cmd, new_priority, slot, required_count, random_draw,
                 input ready);
  modport sink(input valid, cmd, new_priority, slot, required_count, random_draw,
               output ready);
endinterface

[rtl/prs_out_if.sv]
// result channel of the replay sampler
// depends on prs_pkg
interface prs_out_if;
  import prs_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   result_slot;
  logic [OCC_W-1:0]    occupancy;
  logic [PRI_W-1:0]    peak_priority;

  modport source(output valid, status, result_slot, occupancy, peak_priority, input ready);
  modport sink(input valid, status, result_slot, occupancy, peak_priority, output ready);
endinterface

[rtl/prs_weight.sv]
// iterative slot weight unit: (priority + eps)^alpha via log2, multiply, exp2
// one squaring or one table multiply per cycle; depends on prs_pkg
module prs_weight (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [prs_pkg::PRI_W-1:0] prio_i,
  input  logic [prs_pkg::CFG_W-1:0] alpha_i,
  input  logic [prs_pkg::CFG_W-1:0] minp_i,
  output logic                     done_o,
  output logic [prs_pkg::WW-1:0]    weight_o
);
  import prs_pkg::*;

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_LOG  = 3'd1;
  localparam logic [2:0] W_MUL  = 3'd2;
  localparam logic [2:0] W_EXP  = 3'd3;
  localparam logic [2:0] W_SHF  = 3'd4;

  logic [2:0]    phase_q;
  logic [3:0]    cnt_q;
  logic          done_q;
  logic [30:0]   z_q;
  logic [4:0]    e_q;
  logic [15:0]   frac_q;
  logic [23:0]   y_q;
  logic [24:0]   m_q;
  logic [WW-1:0] weight_q;

  logic [24:0]        base;
  logic [4:0]         e_start;
  logic [30:0]        z_start;
  logic [61:0]        sq;
  logic [31:0]        sq_top;
  logic signed [5:0]  esub;
  logic signed [21:0] lg;
  logic signed [38:0] prod;
  logic [49:0]        ep;
  logic               f_bit;
  logic signed [7:0]  sh;
  logic [7:0]         rsh;
  logic [WW-1:0]      w_left;
  logic [WW-1:0]      w_right;

  function automatic logic [4:0] top_bit(input logic [24:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int k = 0; k < 25; k++) begin
      if (v[k]) r = 5'(k);
    end
    return r;
  endfunction

  assign base    = {1'b0, prio_i} + {9'b0, minp_i};
  assign e_start = top_bit(base);
  assign z_start = 31'(base) << (5'd30 - e_start);
  assign sq      = z_q * z_q;
  assign sq_top  = sq[61:30];
  assign esub    = $signed({1'b0, e_q}) - 6'sd16;
  assign lg      = {esub, frac_q};
  assign prod    = $signed({1'b0, alpha_i}) * lg;
  assign ep      = m_q * exp2_step(cnt_q);
  assign f_bit   = y_q[4'd15 - cnt_q];
  assign sh      = $signed(y_q[23:16]) - 8'sd8;
  assign rsh     = -sh;
  assign w_left  = WW'(m_q) << sh[5:0];
  assign w_right = WW'(m_q >> rsh[5:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= W_IDLE;
      cnt_q   <= 4'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        W_IDLE: begin
          if (start_i) begin
            if (base == 25'd0) begin
              done_q <= 1'b1;
            end else begin
              phase_q <= W_LOG;
              cnt_q   <= 4'd0;
            end
          end
        end
        W_LOG: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) phase_q <= W_MUL;
        end
        W_MUL: begin
          cnt_q   <= 4'd0;
          phase_q <= W_EXP;
        end
        W_EXP: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) phase_q <= W_SHF;
        end
        W_SHF: begin
          done_q  <= 1'b1;
          phase_q <= W_IDLE;
        end
        default: phase_q <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      W_IDLE: begin
        if (start_i) begin
          weight_q <= (alpha_i == '0) ? WW'(Q16_ONE) : '0;
          z_q      <= z_start;
          e_q      <= e_start;
          frac_q   <= 16'd0;
        end
      end
      W_LOG: begin
        // squared mantissa at or above 2.0 gives a one bit and halves
        z_q    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        frac_q <= {frac_q[14:0], sq_top[31]};
      end
      W_MUL: begin
        y_q <= prod[38:15];
        m_q <= M_ONE;
      end
      W_EXP: begin
        if (f_bit) m_q <= ep[48:24];
      end
      W_SHF: begin
        weight_q <= sh[7] ? w_right : w_left;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign weight_o = weight_q;

endmodule

[rtl/prs_datapath.sv]
// datapath: priority ring memory, head and count, peak, weight sums, result registers
// depends on prs_pkg and prs_weight
module prs_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prs_pkg::prs_cmd_t             cmd_i,
  output prs_pkg::prs_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [prs_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [prs_pkg::PRI_W-1:0]     in_new_priority_i,
  input  logic [prs_pkg::SLOT_W-1:0]    in_slot_i,
  input  logic [prs_pkg::NEED_W-1:0]    in_required_count_i,
  input  logic [prs_pkg::DRAW_W-1:0]    in_random_draw_i,
  output logic [prs_pkg::STATUS_W-1:0]  out_status_o,
  output logic [prs_pkg::SLOT_W-1:0]    out_result_slot_o,
  output logic [prs_pkg::OCC_W-1:0]     out_occupancy_o,
  output logic [prs_pkg::PRI_W-1:0]     out_peak_priority_o
);
  import prs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = WW + CW;
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int NW = (CW > NEED_W) ? CW : NEED_W;

  logic [CFG_W-1:0]    alpha_q, minp_q;
  logic [AW-1:0]       head_q, idx_q;
  logic [CW-1:0]       count_q;
  logic [PRI_W-1:0]    peak_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [PRI_W-1:0]    newp_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [NEED_W-1:0]   need_q;
  logic [DRAW_W-1:0]   draw_q;
  logic [PRI_W-1:0]    mem [DEPTH];
  logic [PRI_W-1:0]    rd_q;
  logic [TW-1:0]       total_q, cum_q, target_q;
  logic [STATUS_W-1:0] res_status_q, out_status_q;
  logic [SLOT_W-1:0]   res_slot_q, out_slot_q;
  logic [OCC_W-1:0]    out_occ_q;
  logic [PRI_W-1:0]    out_peak_q;

  logic [PRI_W-1:0] push_p, upd_p, wdata;
  logic [AW-1:0]    head_next, waddr;
  logic             upd_ok, sample_go, idx_last, hit, we;
  logic [TW-1:0]    cum_sum, tgt_hi, tgt_lo;
  logic [31:0]      lo_prod;
  logic             w_done;
  logic [WW-1:0]    w_value;

  prs_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.w_start),
    .prio_i  (rd_q),
    .alpha_i (alpha_q),
    .minp_i  (minp_q),
    .done_o  (w_done),
    .weight_o(w_value)
  );

  // an unset push priority takes the peak, or 1.0 before any
  assign push_p = (newp_q != '0) ? newp_q : ((peak_q != '0) ? peak_q : Q16_ONE);
  assign upd_p  = (newp_q > PRI_W'(minp_q)) ? newp_q : PRI_W'(minp_q);
  assign upd_ok = SW'(slot_q) < SW'(count_q);
  assign sample_go = (cmd_q == CMD_SAMPLE) && (count_q != '0) &&
                     !(NW'(count_q) < NW'(need_q));
  assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign idx_last  = (CW'(idx_q) == count_q - CW'(1));
  assign cum_sum   = cum_q + TW'(w_value);
  assign hit       = cum_sum >= target_q;
  assign tgt_hi    = TW'(total_q >> 16) * TW'(draw_q);
  assign lo_prod   = 32'(total_q[15:0]) * 32'(draw_q);
  assign tgt_lo    = TW'(lo_prod >> 16);

  always_comb begin
    we    = 1'b0;
    waddr = head_q;
    wdata = push_p;
    if (cmd_i.exec) begin
      if (cmd_q == CMD_PUSH) begin
        we = 1'b1;
      end else if (cmd_q == CMD_UPDATE && upd_ok) begin
        we    = 1'b1;
        waddr = AW'(slot_q);
        wdata = upd_p;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      minp_q  <= MINP_RST;
      head_q  <= '0;
      count_q <= '0;
      peak_q  <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA: alpha_q <= cfg_data_i;
          REG_MINP:  minp_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        idx_q <= '0;
        case (cmd_q)
          CMD_PUSH: begin
            head_q <= head_next;
            if (count_q != CW'(DEPTH)) count_q <= count_q + CW'(1);
            if (push_p > peak_q) peak_q <= push_p;
          end
          CMD_UPDATE: begin
            if (upd_ok && upd_p > peak_q) peak_q <= upd_p;
          end
          default: ;
        endcase
      end
      if (cmd_i.calc_tgt) idx_q <= '0;
      if (cmd_i.sum_acc || cmd_i.src_acc) idx_q <= idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= in_cmd_i;
      newp_q <= in_new_priority_i;
      slot_q <= in_slot_i;
      need_q <= in_required_count_i;
      draw_q <= in_random_draw_i;
    end
    if (cmd_i.exec) begin
      total_q <= '0;
      cum_q   <= '0;
      case (cmd_q)
        CMD_PUSH: begin
          res_status_q <= ST_OK;
          res_slot_q   <= SLOT_W'(head_q);
        end
        CMD_UPDATE: begin
          res_status_q <= upd_ok ? ST_OK : ST_IGNORED;
          res_slot_q   <= slot_q;
        end
        CMD_SAMPLE: begin
          res_status_q <= sample_go ? ST_OK : ST_SHORT;
          res_slot_q   <= '0;
        end
        default: begin
          res_status_q <= ST_IGNORED;
          res_slot_q   <= '0;
        end
      endcase
    end
    if (cmd_i.sum_acc) total_q <= total_q + TW'(w_value);
    if (cmd_i.calc_tgt) target_q <= tgt_hi + tgt_lo;
    if (cmd_i.src_acc) begin
      cum_q      <= cum_sum;
      res_slot_q <= hit ? SLOT_W'(idx_q) : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_occ_q    <= OCC_W'(count_q);
      out_peak_q   <= peak_q;
    end
  end

  assign sts_o.sample_go = sample_go;
  assign sts_o.w_done    = w_done;
  assign sts_o.idx_last  = idx_last;
  assign sts_o.hit       = hit;

  assign out_status_o        = out_status_q;
  assign out_result_slot_o   = out_slot_q;
  assign out_occupancy_o     = out_occ_q;
  assign out_peak_priority_o = out_peak_q;

endmodule

[rtl/prs_ctrl.sv]
// controller: sequences decode, the weight-sum pass, the search pass and the result
// depends on prs_pkg
module prs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output prs_pkg::prs_cmd_t cmd_o,
  input  prs_pkg::prs_sts_t sts_i
);
  import prs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SUM_RD = 4'd2;
  localparam logic [3:0] S_SUM_GO = 4'd3;
  localparam logic [3:0] S_SUM_WT = 4'd4;
  localparam logic [3:0] S_TGT    = 4'd5;
  localparam logic [3:0] S_SRC_RD = 4'd6;
  localparam logic [3:0] S_SRC_GO = 4'd7;
  localparam logic [3:0] S_SRC_WT = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.sample_go ? S_SUM_RD : S_RESP;
      end
      S_SUM_RD: state_d = S_SUM_GO;
      S_SUM_GO: begin
        cmd_o.w_start = 1'b1;
        state_d       = S_SUM_WT;
      end
      S_SUM_WT: begin
        if (sts_i.w_done) begin
          cmd_o.sum_acc = 1'b1;
          state_d       = sts_i.idx_last ? S_TGT : S_SUM_RD;
        end
      end
      S_TGT: begin
        cmd_o.calc_tgt = 1'b1;
        state_d        = S_SRC_RD;
      end
      S_SRC_RD: state_d = S_SRC_GO;
      S_SRC_GO: begin
        cmd_o.w_start = 1'b1;
        state_d       = S_SRC_WT;
      end
      S_SRC_WT: begin
        if (sts_i.w_done) begin
          cmd_o.src_acc = 1'b1;
          state_d       = (sts_i.hit || sts_i.idx_last) ? S_RESP : S_SRC_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/prioritized_replay_sampler.sv]
// top level of the prioritized replay sampler: controller plus datapath
// depends on prs_pkg, prs_in_if, prs_out_if, prs_ctrl, prs_datapath
//
// usage:
// - in_i carries one command transaction: push, update priority or sample;
//   out_o returns exactly one result transaction per command, in order
// - cfg_we_i / cfg_idx_i / cfg_data_i write alpha (index 0) or the epsilon
//   floor (index 1); write them only while no command is in flight
// - push, update and unused codes go from accept through the decode and
//   response states to result valid, with no weight pass
// - a sample walks the stored entries twice (weight sum, then cumulative
//   search, which stops at the hit); each entry waits on the registered
//   memory read and on the iterative weight unit with 16 log2 squaring
//   steps and 16 exp2 table multiplies, one multiply a cycle
// - a command is taken only while the controller is idle; a finished result
//   sits in the output register, so the next command is taken even while
//   the receiver stalls, and its result waits until the register frees
// - reset clears head, occupancy, peak and the config registers to their
//   defaults; the priority memory is not cleared, only written slots are read
module prioritized_replay_sampler #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prs_in_if.sink                        in_i,
  prs_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prs_pkg::CFG_W-1:0]     cfg_data_i
);
  import prs_pkg::*;

  prs_cmd_t cmd;
  prs_sts_t sts;

  // sequencing of each command
  prs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // storage, arithmetic and result registers
  prs_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_cmd_i           (in_i.cmd),
    .in_new_priority_i  (in_i.new_priority),
    .in_slot_i          (in_i.slot),
    .in_required_count_i(in_i.required_count),
    .in_random_draw_i   (in_i.random_draw),
    .out_status_o       (out_o.status),
    .out_result_slot_o  (out_o.result_slot),
    .out_occupancy_o    (out_o.occupancy),
    .out_peak_priority_o(out_o.peak_priority)
  );

endmodule

[rtl/prs_checker.sv]
// port-level checks for the replay sampler, bound to the top level
// depends on prs_pkg and prioritized_replay_sampler_defines.svh
`include "prioritized_replay_sampler_defines.svh"

module prs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [prs_pkg::STATUS_W-1:0] out_status_i,
  input logic [prs_pkg::SLOT_W-1:0]   out_result_slot_i,
  input logic [prs_pkg::OCC_W-1:0]    out_occupancy_i,
  input logic [prs_pkg::PRI_W-1:0]    out_peak_priority_i
);
  import prs_pkg::*;

  logic             in_acc, out_acc;
  logic [1:0]       pend_q;
  logic [PRI_W-1:0] last_peak_q;
  logic [OCC_W-1:0] last_occ_q;
  logic [STATUS_W+SLOT_W+OCC_W+PRI_W-1:0] out_word;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign out_word = {out_status_i, out_result_slot_i, out_occupancy_i, out_peak_priority_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      last_peak_q <= '0;
      last_occ_q  <= '0;
    end else begin
      if (in_acc && !out_acc) pend_q <= pend_q + 2'd1;
      else if (!in_acc && out_acc) pend_q <= pend_q - 2'd1;
      if (out_acc) begin
        last_peak_q <= out_peak_priority_i;
        last_occ_q  <= out_occupancy_i;
      end
    end
  end

  `PRS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `PRS_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_word))
  `PRS_ASSERT_IMP(a_peak_mono, out_valid_i, out_peak_priority_i >= last_peak_q)
  `PRS_ASSERT_IMP(a_occ_mono, out_valid_i, out_occupancy_i >= last_occ_q)
  `PRS_ASSERT_IMP(a_no_orphan, out_valid_i, pend_q != 2'd0)

endmodule

bind prioritized_replay_sampler prs_checker u_prs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_status_i       (out_o.status),
  .out_result_slot_i  (out_o.result_slot),
  .out_occupancy_i    (out_o.occupancy),
  .out_peak_priority_i(out_o.peak_priority)
);
